// ----- hdl/per_channel_dequantizer_unit_macros.svh -----
// ----------------------------------------------------------------------------
// per_channel_dequantizer_unit_macros.svh
// Assertion macros used by the dequantizer checker.
// ----------------------------------------------------------------------------
`ifndef PER_CHANNEL_DEQUANTIZER_UNIT_MACROS_SVH
`define PER_CHANNEL_DEQUANTIZER_UNIT_MACROS_SVH

// same-cycle implication
`define PCDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCDQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pcdq_pkg.sv -----
// ----------------------------------------------------------------------------
// pcdq_pkg
// Types and constants of the per-channel dequantizer.
// ----------------------------------------------------------------------------
package pcdq_pkg;

  localparam int unsigned MAX_CHANNELS = 256;
  localparam int unsigned SAMPLE_BITS  = 16;

  localparam int unsigned SCALE_W    = 32;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned INNER_W    = 25;
  localparam int unsigned POS_W      = 24;
  localparam int unsigned VALUE_W    = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [SCALE_W-1:0] ONE_Q8_24   = 32'h0100_0000;
  localparam logic [SCALE_W-1:0] RECIP_RESET = 32'd33818640;
  localparam logic [INNER_W-1:0] INNER_LIMIT = 25'h100_0000;
  localparam logic [63:0]        POS_MAX     = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0]        NEG_MAX     = 64'h0000_8000_0000_0000;

  typedef enum logic {
    REQ_DATA        = 1'b0,
    REQ_SCALE_WRITE = 1'b1
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DUAL_SCALE_MODE = 3'd0,
    CFG_CHANNEL_COUNT   = 3'd1,
    CFG_INNER_SIZE      = 3'd2,
    CFG_SECOND_SCALE    = 3'd3,
    CFG_RECIP_MAX_RANGE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    req_type_e                       req_type;
    logic [CH_W-1:0]                 scale_index;
    logic [SCALE_W-1:0]              scale_value;
    logic signed [SAMPLE_BITS-1:0]   sample;
    logic                            first_element;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [CH_W-1:0]           channel;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    logic                 dual_scale_mode;
    logic [CNT_W-1:0]     channel_count;
    logic [INNER_W-1:0]   inner_size;
    logic [SCALE_W-1:0]   second_scale;
    logic [SCALE_W-1:0]   recip_max_range;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]        channel;
    logic                   neg;
    logic [SAMPLE_BITS-1:0] mag;
  } job_t;

endpackage

// ----- hdl/pcdq_ram.sv -----
// ----------------------------------------------------------------------------
// pcdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/pcdq_pos.sv -----
// ----------------------------------------------------------------------------
// pcdq_pos
// Element position tracker: gives the channel of each data item.
// ----------------------------------------------------------------------------
module pcdq_pos #(
  parameter int unsigned MAX_CHANNELS = pcdq_pkg::MAX_CHANNELS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  logic                      first_i,
  input  pcdq_pkg::cfg_t            cfg_i,
  output logic [pcdq_pkg::CH_W-1:0] channel_o
);

  logic [pcdq_pkg::CNT_W-1:0]   nch;
  logic [pcdq_pkg::INNER_W-1:0] ninner;
  logic [pcdq_pkg::POS_W-1:0]   inner_q, inner_d, ip0;
  logic [pcdq_pkg::CH_W-1:0]    chan_q, chan_d, cp0;
  logic [pcdq_pkg::INNER_W-1:0] ip_inc;
  logic [pcdq_pkg::CNT_W-1:0]   cp_inc;

  always_comb begin
    nch = cfg_i.channel_count;
    if (nch == '0) begin
      nch = pcdq_pkg::CNT_W'(1);
    end
    if (32'(nch) > MAX_CHANNELS) begin
      nch = pcdq_pkg::CNT_W'(MAX_CHANNELS);
    end
    ninner = cfg_i.inner_size;
    if (ninner == '0) begin
      ninner = pcdq_pkg::INNER_W'(1);
    end
    if (ninner > pcdq_pkg::INNER_LIMIT) begin
      ninner = pcdq_pkg::INNER_LIMIT;
    end

    ip0 = first_i ? '0 : inner_q;
    if ({1'b0, ip0} >= ninner) begin
      ip0 = '0;
    end
    cp0 = first_i ? '0 : chan_q;
    if ({1'b0, cp0} >= nch) begin
      cp0 = '0;
    end

    ip_inc = {1'b0, ip0} + pcdq_pkg::INNER_W'(1);
    cp_inc = {1'b0, cp0} + pcdq_pkg::CNT_W'(1);
    if (ip_inc >= ninner) begin
      inner_d = '0;
      chan_d  = (cp_inc >= nch) ? '0 : cp_inc[pcdq_pkg::CH_W-1:0];
    end else begin
      inner_d = ip_inc[pcdq_pkg::POS_W-1:0];
      chan_d  = cp0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= '0;
      chan_q  <= '0;
    end else if (advance_i) begin
      inner_q <= inner_d;
      chan_q  <= chan_d;
    end
  end

  assign channel_o = cp0;

endmodule

// ----- hdl/pcdq_mac.sv -----
// ----------------------------------------------------------------------------
// pcdq_mac
// Word-serial multiply chain (|q| * scale * (second_scale or 1.0) * recip), rounding,
// saturation and output register.
// ----------------------------------------------------------------------------
module pcdq_mac (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  pcdq_pkg::job_t               job_i,
  input  pcdq_pkg::cfg_t               cfg_i,
  input  logic [pcdq_pkg::SCALE_W-1:0] scale_i,
  output logic                         busy_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output pcdq_pkg::out_item_t          out_item_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROUND,
    ST_SAT
  } state_e;

  typedef enum logic [1:0] {
    PASS_SCALE,
    PASS_TWO,
    PASS_RECIP
  } pass_e;

  state_e                       state_q;
  pass_e                        pass_q;
  logic [1:0]                   word_q;
  logic [31:0]                  w_q [4];
  logic [31:0]                  carry_q;
  logic [63:0]                  hi_q;
  logic                         neg_q;
  logic [pcdq_pkg::CH_W-1:0]    chan_q;
  logic                         out_valid_q;
  pcdq_pkg::out_item_t          out_q;

  logic [31:0]                  k;
  logic [63:0]                  prod, t, rnd, lim, mag_lim;
  logic                         sat;
  logic                         load_out;
  logic [pcdq_pkg::VALUE_W-1:0] res;

  always_comb begin
    case (pass_q)
      PASS_SCALE: k = scale_i;
      PASS_TWO:   k = cfg_i.dual_scale_mode ? cfg_i.second_scale : pcdq_pkg::ONE_Q8_24;
      default:    k = cfg_i.recip_max_range;
    endcase
    prod    = w_q[0] * k;
    t       = prod + {32'b0, carry_q};
    rnd     = {w_q[3], w_q[2]} + 64'(w_q[1][31]);
    lim     = neg_q ? pcdq_pkg::NEG_MAX : pcdq_pkg::POS_MAX;
    sat     = hi_q > lim;
    mag_lim = sat ? lim : hi_q;
    res     = neg_q ? (~mag_lim[pcdq_pkg::VALUE_W-1:0] + pcdq_pkg::VALUE_W'(1))
                    : mag_lim[pcdq_pkg::VALUE_W-1:0];
    load_out = (state_q == ST_SAT) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= PASS_SCALE;
      word_q      <= '0;
      carry_q     <= '0;
      hi_q        <= '0;
      neg_q       <= 1'b0;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < 4; i++) begin
        w_q[i] <= '0;
      end
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            w_q[0]  <= 32'(job_i.mag);
            w_q[1]  <= '0;
            w_q[2]  <= '0;
            w_q[3]  <= '0;
            neg_q   <= job_i.neg;
            chan_q  <= job_i.channel;
            pass_q  <= PASS_SCALE;
            word_q  <= '0;
            carry_q <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          for (int i = 0; i < 3; i++) begin
            w_q[i] <= w_q[i+1];
          end
          w_q[3] <= t[31:0];
          if (word_q == 2'd3) begin
            word_q  <= '0;
            carry_q <= '0;
            if (pass_q == PASS_RECIP) begin
              state_q <= ST_ROUND;
            end else begin
              pass_q <= pass_e'(pass_q + 2'd1);
            end
          end else begin
            word_q  <= word_q + 2'd1;
            carry_q <= t[63:32];
          end
        end
        ST_ROUND: begin
          hi_q    <= rnd;
          state_q <= ST_SAT;
        end
        ST_SAT: begin
          if (load_out) begin
            out_q.value     <= res;
            out_q.channel   <= chan_q;
            out_q.saturated <= sat;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- hdl/per_channel_dequantizer_unit.sv -----
// ----------------------------------------------------------------------------
// per_channel_dequantizer_unit
// Per-channel symmetric dequantizer: signed samples to saturated Q32.16.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o, in_item_i) carries two kinds of item:
//   scale writes load one Q8.24 entry of the scale RAM and give no result;
//   data items give one result on the output channel (out_valid_o /
//   out_ready_i, out_item_o) with value, channel and saturation flag.
// The channel of a data item is (position / inner_size) mod channel_count,
// with first_element restarting the position count.
// A scale write leaves the input ready. A data item, once accepted, goes
// through a multiply phase on one shared 32x32 multiplier (three
// passes over a 4-word product, starting on the scale word read at
// acceptance), then a rounding and a saturation step. One data item is in
// flight at a time; in_ready_o is low while it is, so no new item is taken
// until it has left the saturation stage.
// The result sits in an output register; if the receiver stalls, the next
// item is still accepted and finishes into the saturation stage, where it
// waits until the output register is free.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once
// and are meant for idle periods. Reset restores register defaults and
// clears the position counters; scale RAM contents are undefined until
// written.
// ----------------------------------------------------------------------------
module per_channel_dequantizer_unit #(
  parameter int unsigned MAX_CHANNELS = pcdq_pkg::MAX_CHANNELS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  pcdq_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output pcdq_pkg::out_item_t             out_item_o,
  input  logic                            cfg_we_i,
  input  logic [pcdq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pcdq_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  pcdq_pkg::cfg_t                cfg_q;
  pcdq_pkg::job_t                job;
  logic                          busy;
  logic                          accept, data_acc, wr_acc;
  logic [pcdq_pkg::CH_W-1:0]     channel;
  logic [pcdq_pkg::SAMPLE_BITS-1:0] raw;
  logic [pcdq_pkg::SCALE_W-1:0]  scale_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dual_scale_mode <= 1'b0;
      cfg_q.channel_count   <= pcdq_pkg::CNT_W'(1);
      cfg_q.inner_size      <= pcdq_pkg::INNER_W'(1);
      cfg_q.second_scale    <= pcdq_pkg::ONE_Q8_24;
      cfg_q.recip_max_range <= pcdq_pkg::RECIP_RESET;
    end else if (cfg_we_i) begin
      unique case (pcdq_pkg::cfg_idx_e'(cfg_idx_i))
        pcdq_pkg::CFG_DUAL_SCALE_MODE: cfg_q.dual_scale_mode <= cfg_data_i[0];
        pcdq_pkg::CFG_CHANNEL_COUNT:
          cfg_q.channel_count <= cfg_data_i[pcdq_pkg::CNT_W-1:0];
        pcdq_pkg::CFG_INNER_SIZE:
          cfg_q.inner_size <= cfg_data_i[pcdq_pkg::INNER_W-1:0];
        pcdq_pkg::CFG_SECOND_SCALE:    cfg_q.second_scale <= cfg_data_i;
        pcdq_pkg::CFG_RECIP_MAX_RANGE: cfg_q.recip_max_range <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !busy;
  assign accept     = in_valid_i && in_ready_o;
  assign data_acc   = accept && (in_item_i.req_type == pcdq_pkg::REQ_DATA);
  assign wr_acc     = accept && (in_item_i.req_type == pcdq_pkg::REQ_SCALE_WRITE)
                      && (32'(in_item_i.scale_index) < MAX_CHANNELS);

  assign raw         = in_item_i.sample;
  assign job.channel = channel;
  assign job.neg     = raw[pcdq_pkg::SAMPLE_BITS-1];
  assign job.mag     = job.neg ? (~raw + pcdq_pkg::SAMPLE_BITS'(1)) : raw;

  pcdq_pos #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_pos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (data_acc),
    .first_i   (in_item_i.first_element),
    .cfg_i     (cfg_q),
    .channel_o (channel)
  );

  pcdq_ram #(
    .WIDTH (pcdq_pkg::SCALE_W),
    .DEPTH (MAX_CHANNELS)
  ) u_scale_ram (
    .clk_i   (clk_i),
    .we_i    (wr_acc),
    .waddr_i (AW'(in_item_i.scale_index)),
    .wdata_i (in_item_i.scale_value),
    .re_i    (data_acc),
    .raddr_i (AW'(channel)),
    .rdata_o (scale_rd)
  );

  pcdq_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (data_acc),
    .job_i       (job),
    .cfg_i       (cfg_q),
    .scale_i     (scale_rd),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- hdl/pcdq_checker.sv -----
// ----------------------------------------------------------------------------
// pcdq_checker
// Port-level checks of the per-channel dequantizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "per_channel_dequantizer_unit_macros.svh"

module pcdq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input pcdq_pkg::in_item_t              in_item_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input pcdq_pkg::out_item_t             out_item_o
);

  logic data_acc, wr_acc, clamp_ok;

  assign data_acc = in_valid_i && in_ready_o && (in_item_i.req_type == pcdq_pkg::REQ_DATA);
  assign wr_acc   = in_valid_i && in_ready_o
                    && (in_item_i.req_type == pcdq_pkg::REQ_SCALE_WRITE);
  assign clamp_ok = (out_item_o.value == 48'h7FFF_FFFF_FFFF)
                    || (out_item_o.value == 48'h8000_0000_0000);

  `PCDQ_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "output item dropped or changed while stalled")
  `PCDQ_ASSERT_NXT(a_data_busy, data_acc, !in_ready_o, "ready after a data item was accepted")
  `PCDQ_ASSERT_NXT(a_write_free, wr_acc, in_ready_o, "scale write blocked the input")
  `PCDQ_ASSERT_IMP(a_out_from_busy, $rose(out_valid_o), !$past(in_ready_o), "result without a data item in flight")
  `PCDQ_ASSERT_IMP(a_sat_limit, out_valid_o && out_item_o.saturated, clamp_ok, "saturated value not at a limit")

endmodule

bind per_channel_dequantizer_unit pcdq_checker u_pcdq_checker (.*);
